/* design/mcpi_pkg.sv */
// Shared types and constants for the four-channel motor current PI controller.
// Field widths, register indexes, sequencer states and fixed-point constants.
// No dependencies.
package mcpi_pkg;

  // Beat field widths
  localparam int CH_W   = 2;
  localparam int ADC_W  = 16;
  localparam int VEL_W  = 20;
  localparam int CUR_W  = 17;
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 17;
  localparam int DUTY_W = 16;
  localparam int INV_W  = 4;

  localparam int CH_COUNT = 2 ** CH_W;

  // Packed stream layout
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;
  localparam int VEL_LSB     = ADC_W;
  localparam int DES_LSB     = ADC_W + VEL_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (DUTY_W + 1 + CUR_W + 1);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 17;

  typedef enum logic [CFG_AW-1:0] {
    CFG_PROP_GAIN     = 3'd0,
    CFG_INTEGRAL_GAIN = 3'd1,
    CFG_INT_LIMIT     = 3'd2,
    CFG_RESISTANCE    = 3'd3,
    CFG_BEMF_GAIN     = 3'd4,
    CFG_SUPPLY_RECIP  = 3'd5,
    CFG_DUTY_LIMIT    = 3'd6,
    CFG_DIR_INVERT    = 3'd7
  } cfg_reg_t;

  // Datapath widths
  localparam int INT_W    = 18;              // integrator, Q12 amps
  localparam int ERR_W    = 18;
  localparam int RAW15_W  = ADC_W + 4;
  localparam int MUL_A_W  = GAIN_W + 1;      // unsigned gain as signed operand
  localparam int MUL_B_W  = 21;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int VOLT_W   = 40;              // Q24 volts
  localparam int PART_W   = 20;              // low half of the volts split
  localparam int PWR_W    = 57;              // Q40 duty before rounding
  localparam int RND_SH   = 25;
  localparam int MAG_W    = PWR_W - RND_SH;

  localparam logic [CUR_W:0]   MEAS_ZERO = 18'd61440;
  localparam logic [DUTY_W-1:0] DUTY_ONE = 16'd32768;
  localparam logic [PWR_W-1:0] RND_HALF  = 57'd1 << (RND_SH - 1);
  localparam logic [PWR_W-1:0] RND_NEG   = RND_HALF + 57'd1;

  // Register reset values
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN     = 16'd1024;
  localparam logic [GAIN_W-1:0] RST_INTEGRAL_GAIN = 16'd102;
  localparam logic [LIM_W-1:0]  RST_INT_LIMIT     = 17'd12288;
  localparam logic [GAIN_W-1:0] RST_RESISTANCE    = 16'd512;
  localparam logic [GAIN_W-1:0] RST_BEMF_GAIN     = 16'd15812;
  localparam logic [GAIN_W-1:0] RST_SUPPLY_RECIP  = 16'd5461;
  localparam logic [DUTY_W-1:0] RST_DUTY_LIMIT    = 16'd0;
  localparam logic [INV_W-1:0]  RST_DIR_INVERT    = 4'd12;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_ACC,
    S_ITERM,
    S_VSUM,
    S_MLO,
    S_MHI,
    S_SUM,
    S_RND,
    S_FIN
  } state_t;

endpackage

/* design/motor_current_pi_controller.sv */
// Motor current PI controller: per-channel integrator memory, shared multiplier.
// Depends on mcpi_pkg.
//
//  channel   dir  group                          beat contents
//  in        in   in_tvalid/in_tready/in_tdata   sample, velocity, desired current
//  out       out  out_tvalid/out_tready/out_tdata duty, direction, measured current
//  cfg       in   cfg_we/cfg_index/cfg_data      one register write per cycle
//
// The sequencer runs six products through the single 17x21 multiplier, then rounds and clamps;
// the result is loaded into the output register, and only then is the next beat taken.
// Integrators sit in a one-entry-per-channel memory read on accept and written
// back once; per-entry valid bits make entries read as zero after reset.
// Reset is synchronous, active low. A result waits in the output register;
// a new item is taken meanwhile and stalls only at its final step.
module motor_current_pi_controller #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mcpi_pkg::CFG_AW-1:0]        cfg_index,
  input  logic [mcpi_pkg::CFG_DW-1:0]        cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // adc_current[15:0], encoder_velocity[35:16], desired_current[52:36]
  input  logic [mcpi_pkg::IN_TDATA_W-1:0]    in_tdata,
  // channel[1:0]
  input  logic [mcpi_pkg::CH_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // duty_magnitude[15:0], direction[16], measured_current[33:17], duty_clamped[34]
  output logic [mcpi_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_channel[1:0]
  output logic [mcpi_pkg::CH_W-1:0]          out_tuser
);
  import mcpi_pkg::*;

  localparam int DEPTH = (NUM_CHANNELS < CH_COUNT) ? NUM_CHANNELS : CH_COUNT;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [GAIN_W-1:0] prop_gain_r, integral_gain_r, resistance_r, bemf_gain_r;
  logic [GAIN_W-1:0] supply_recip_r;
  logic [LIM_W-1:0]  int_limit_r;
  logic [DUTY_W-1:0] duty_limit_r;
  logic [INV_W-1:0]  dir_invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= RST_PROP_GAIN;
      integral_gain_r <= RST_INTEGRAL_GAIN;
      int_limit_r     <= RST_INT_LIMIT;
      resistance_r    <= RST_RESISTANCE;
      bemf_gain_r     <= RST_BEMF_GAIN;
      supply_recip_r  <= RST_SUPPLY_RECIP;
      duty_limit_r    <= RST_DUTY_LIMIT;
      dir_invert_r    <= RST_DIR_INVERT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PROP_GAIN:     prop_gain_r     <= cfg_data[GAIN_W-1:0];
        CFG_INTEGRAL_GAIN: integral_gain_r <= cfg_data[GAIN_W-1:0];
        CFG_INT_LIMIT:     int_limit_r     <= cfg_data[LIM_W-1:0];
        CFG_RESISTANCE:    resistance_r    <= cfg_data[GAIN_W-1:0];
        CFG_BEMF_GAIN:     bemf_gain_r     <= cfg_data[GAIN_W-1:0];
        CFG_SUPPLY_RECIP:  supply_recip_r  <= cfg_data[GAIN_W-1:0];
        CFG_DUTY_LIMIT:    duty_limit_r    <= cfg_data[DUTY_W-1:0];
        CFG_DIR_INVERT:    dir_invert_r    <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat fields
  logic [ADC_W-1:0]        in_adc;
  logic signed [VEL_W-1:0] in_vel;
  logic signed [CUR_W-1:0] in_des;
  logic                    in_acc;
  logic                    ch_ok;

  assign in_adc = in_tdata[ADC_W-1:0];
  assign in_vel = signed'(in_tdata[VEL_LSB +: VEL_W]);
  assign in_des = signed'(in_tdata[DES_LSB +: CUR_W]);
  assign in_acc = in_tvalid && in_tready;
  assign ch_ok  = int'(in_tuser) < NUM_CHANNELS;

  state_t state_r, state_nxt;
  logic   out_free;
  logic   out_load;

  assign out_free = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        // drop beats for channels that are not built
        if (in_tvalid && ch_ok) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR:   state_nxt = S_ACC;
      S_ACC:   state_nxt = S_ITERM;
      S_ITERM: state_nxt = S_VSUM;
      S_VSUM:  state_nxt = S_MLO;
      S_MLO:   state_nxt = S_MHI;
      S_MHI:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_RND;
      S_RND:   state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Item registers
  logic [CH_W-1:0]         ch_r;
  logic [ADC_W-1:0]        raw_r;
  logic signed [VEL_W-1:0] vel_r;
  logic signed [CUR_W-1:0] des_r;
  logic [IDX_W-1:0]        idx_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r  <= in_tuser;
      raw_r <= in_adc;
      vel_r <= in_vel;
      des_r <= in_des;
      idx_r <= in_tuser[IDX_W-1:0];
    end
  end

  // Integrator memory with valid bits
  logic signed [INT_W-1:0] int_mem [DEPTH];
  logic signed [INT_W-1:0] rd_r;
  logic [DEPTH-1:0]        valid_r;
  logic                    wr_en;
  logic signed [INT_W-1:0] acc_c;

  assign wr_en = (state_r == S_ACC);

  always_ff @(posedge clk) begin
    if (in_acc && ch_ok) begin
      rd_r <= int_mem[in_tuser[IDX_W-1:0]];
    end
    if (wr_en) begin
      int_mem[idx_r] <= acc_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[idx_r] <= 1'b1;
    end
  end

  // Current conversion and error
  logic [RAW15_W-1:0]      raw15;
  logic [CUR_W-1:0]        scaled;
  logic signed [CUR_W:0]   meas_c;
  logic signed [ERR_W-1:0] err_c;
  logic signed [CUR_W-1:0] meas_r;
  logic signed [ERR_W-1:0] err_r;

  assign raw15  = ({4'b0, raw_r} << 4) - {4'b0, raw_r};
  assign scaled = CUR_W'((raw15 + RAW15_W'(4)) >> 3);
  assign meas_c = signed'(MEAS_ZERO) - signed'({1'b0, scaled});
  assign err_c  = ERR_W'(des_r) - ERR_W'(meas_c);

  // Integrator update with anti-windup clamp
  logic signed [INT_W-1:0] integ;
  logic signed [INT_W:0]   isum;
  logic signed [INT_W:0]   lim_c;
  logic signed [INT_W:0]   acc_w;
  logic signed [INT_W-1:0] acc_r;

  assign integ = valid_r[idx_r] ? rd_r : '0;
  assign isum  = (INT_W+1)'(integ) + (INT_W+1)'(err_r);
  assign lim_c = signed'({2'b00, int_limit_r});

  always_comb begin
    if (isum > lim_c) begin
      acc_w = lim_c;
    end else if (isum < -lim_c) begin
      acc_w = -lim_c;
    end else begin
      acc_w = isum;
    end
  end

  assign acc_c = acc_w[INT_W-1:0];

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_c;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [VOLT_W-1:0]  volts_r;

  always_comb begin
    case (state_r)
      S_ERR: begin
        mul_a = signed'({1'b0, bemf_gain_r});
        mul_b = MUL_B_W'(vel_r);
      end
      S_ACC: begin
        mul_a = signed'({1'b0, prop_gain_r});
        mul_b = MUL_B_W'(err_r);
      end
      S_ITERM: begin
        mul_a = signed'({1'b0, integral_gain_r});
        mul_b = MUL_B_W'(acc_r);
      end
      S_MLO: begin
        mul_a = signed'({1'b0, supply_recip_r});
        mul_b = signed'({1'b0, volts_r[PART_W-1:0]});
      end
      S_MHI: begin
        mul_a = signed'({1'b0, supply_recip_r});
        mul_b = MUL_B_W'(signed'(volts_r[VOLT_W-1:PART_W]));
      end
      default: begin
        // resistance feedforward starts on the accept cycle
        mul_a = signed'({1'b0, resistance_r});
        mul_b = MUL_B_W'(in_des);
      end
    endcase
  end

  assign prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Voltage sum, duty scaling and rounding
  logic signed [PROD_W-1:0] lo_r;
  logic signed [PWR_W-1:0]  pwr_r;
  logic [PWR_W-1:0]         rnd_c;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;

  assign rnd_c = pwr_r[PWR_W-1] ? (~pwr_r + RND_NEG) : (pwr_r + RND_HALF);

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    case (state_r)
      S_ERR: begin
        meas_r  <= meas_c[CUR_W-1:0];
        err_r   <= err_c;
        volts_r <= VOLT_W'(prod_r) <<< 4;
      end
      S_ACC: begin
        acc_r   <= acc_c;
        volts_r <= volts_r + VOLT_W'(prod_r);
      end
      S_ITERM, S_VSUM: begin
        volts_r <= volts_r + (VOLT_W'(prod_r) <<< 4);
      end
      S_MHI: begin
        lo_r <= prod_r;
      end
      S_SUM: begin
        pwr_r <= (PWR_W'(prod_r) <<< PART_W) + PWR_W'(lo_r);
      end
      S_RND: begin
        neg_r <= pwr_r[PWR_W-1];
        mag_r <= rnd_c[PWR_W-1:RND_SH];
      end
      default: ;
    endcase
  end

  // Clamp, direction and output register
  logic [DUTY_W-1:0] dlim;
  logic              clamp_c;
  logic [DUTY_W-1:0] duty_c;
  logic              dir_c;
  logic              out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [CH_W-1:0]   out_tuser_r;

  assign dlim    = (duty_limit_r > DUTY_ONE) ? DUTY_ONE : duty_limit_r;
  assign clamp_c = mag_r > MAG_W'(dlim);
  assign duty_c  = clamp_c ? dlim : mag_r[DUTY_W-1:0];
  assign dir_c   = (neg_r && (duty_c != '0)) ^ dir_invert_r[ch_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, clamp_c, meas_r, dir_c, duty_c};
      out_tuser_r <= ch_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
